// ===== rtl/psl_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table of the polar scan lookup.
package psl_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int PIX_W    = 11;
	localparam int SIZE_W   = 12;
	localparam int ANGLE_W  = 16;
	localparam int RADIUS_W = 14;
	localparam int CENTER_W = 15;
	localparam int COORD_W  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_WIDTH,
		REG_TARGET_HEIGHT,
		REG_ANGLE_FIRST,
		REG_ANGLE_LAST,
		REG_RADIUS_FIRST,
		REG_RADIUS_LAST,
		REG_CENTER_X,
		REG_CENTER_Y
	} cfg_reg_t;

	localparam logic [SIZE_W-1:0]   RST_TARGET_WIDTH  = 12'd512;
	localparam logic [SIZE_W-1:0]   RST_TARGET_HEIGHT = 12'd512;
	localparam logic [ANGLE_W-1:0]  RST_ANGLE_FIRST   = 16'd23300;
	localparam logic [ANGLE_W-1:0]  RST_ANGLE_LAST    = 16'd30800;
	localparam logic [RADIUS_W-1:0] RST_RADIUS_FIRST  = 14'd1856;
	localparam logic [RADIUS_W-1:0] RST_RADIUS_LAST   = 14'd8640;
	localparam logic [CENTER_W-1:0] RST_CENTER_X      = 15'd5440;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y      = 15'd8576;

	localparam int TURN_CENTI = 36000;

	// Long division cells: remainder and divisor width, shifting word width
	localparam int DIV_W  = 28;
	localparam int WORD_W = 32;

	// Steps of each division chain
	localparam int MOD_STEPS  = 29;
	localparam int FRAC_STEPS = 32;
	localparam int OFS_STEPS  = 16;

	localparam int PN_W    = 30;
	localparam int RNUM_W  = 26;
	localparam int MAG_W   = 31;
	localparam int PROD_W  = RNUM_W + MAG_W;

	// CORDIC
	localparam int CORDIC_STEPS    = 16;
	localparam int ATAN_ENTRIES    = 24;
	localparam int CORDIC_LEN      = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS
	                                                                : ATAN_ENTRIES;
	localparam int STEP_W          = 5;
	localparam int ATAN_W          = 30;
	localparam int CX_W            = 33;
	localparam int CZ_W            = 32;
	localparam int CORDIC_GAIN_INV = 652032874;

	localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81
	};

	typedef struct packed {
		logic              vld;
		logic [DIV_W-1:0]  rem;
		logic [WORD_W-1:0] word;
	} div_step_t;

	typedef struct packed {
		logic                   vld;
		logic signed [CX_W-1:0] x;
		logic signed [CX_W-1:0] y;
		logic signed [CZ_W-1:0] z;
	} rot_step_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] source_x;
		logic signed [COORD_W-1:0] source_y;
	} coord_t;

	function automatic logic [ATAN_W-1:0] atan_step(input logic [STEP_W-1:0] step);
		return (step < STEP_W'(ATAN_ENTRIES)) ? ATAN_TAB[step] : '0;
	endfunction

endpackage

// ===== rtl/psl_if.sv =====
`timescale 1ns / 1ps
// Handshake interfaces: pixel requests, coordinate results and register writes.
interface psl_req_if import psl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] column;
	logic [PIX_W-1:0] row;

	modport source(output valid, column, row, input ready);
	modport sink(input valid, column, row, output ready);
endinterface

interface psl_res_if import psl_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] source_x;
	logic signed [COORD_W-1:0] source_y;

	modport source(output valid, source_x, source_y, input ready);
	modport sink(input valid, source_x, source_y, output ready);
endinterface

interface psl_cfg_if import psl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/psl_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring long-division step: shift in a dividend bit, subtract if it fits.
module psl_div_cell import psl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [DIV_W-1:0] divisor,
	input  div_step_t        d_i,
	output div_step_t        d_o
);

	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;
	logic              take;
	logic              vld_q;
	logic [DIV_W-1:0]  rem_q;
	logic [WORD_W-1:0] word_q;

	assign trial = {d_i.rem, d_i.word[WORD_W-1]};
	assign take  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d_i.vld;
		end
	end

	// Quotient bits enter at the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			word_q <= {d_i.word[WORD_W-2:0], take};
		end
	end

	assign d_o = '{vld: vld_q, rem: rem_q, word: word_q};

endmodule

// ===== rtl/psl_cordic_cell.sv =====
`timescale 1ns / 1ps
// One CORDIC rotation step in rotation mode, step number set by a tied input.
module psl_cordic_cell import psl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [STEP_W-1:0] step,
	input  rot_step_t         r_i,
	output rot_step_t         r_o
);

	logic signed [CX_W-1:0] dx;
	logic signed [CX_W-1:0] dy;
	logic signed [CZ_W-1:0] da;
	logic                   up;
	logic                   vld_q;
	logic signed [CX_W-1:0] x_q;
	logic signed [CX_W-1:0] y_q;
	logic signed [CZ_W-1:0] z_q;

	assign dx = r_i.y >>> step;
	assign dy = r_i.x >>> step;
	assign da = $signed({{(CZ_W-ATAN_W){1'b0}}, atan_step(step)});
	assign up = !r_i.z[CZ_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= r_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= up ? r_i.x - dx : r_i.x + dx;
			y_q <= up ? r_i.y + dy : r_i.y - dy;
			z_q <= up ? r_i.z - da : r_i.z + da;
		end
	end

	assign r_o = '{vld: vld_q, x: x_q, y: y_q, z: z_q};

endmodule

// ===== rtl/psl_out_buf.sv =====
`timescale 1ns / 1ps
// Two-entry result buffer that decouples the pipeline advance from the result ready.
module psl_out_buf import psl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  coord_t           data_i,
	output logic             room,
	psl_res_if.source        rsp
);

	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       pop;
	coord_t     buf_q [2];

	assign pop = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= data_i;
		end
	end

	assign room         = cnt_q != 2'd2;
	assign rsp.valid    = cnt_q != 2'd0;
	assign rsp.source_x = buf_q[rd_q].source_x;
	assign rsp.source_y = buf_q[rd_q].source_y;

endmodule

// ===== rtl/polar_scan_lookup_coordinates_top.sv =====
`timescale 1ns / 1ps
// Top level of the polar scan lookup: pixel index in, source coordinate out.
// Each request (column, row) of the fan-shaped target image returns the source
// point center + r * (cos phi, sin phi) in 1/16 pixel, saturated to 16 bits.
// One request is taken every clock while the result buffer has room; each
// request passes the cell chains: a 29-step modulo division that folds
// the angle into one turn, a 32-step division that makes it a binary angle, the
// CORDIC rotation (one cell per step) and a 16-step division by the height per
// coordinate, plus single stages of multiply, add and select. All stages
// advance together; a two-entry result buffer keeps requests flowing while a
// result waits, and the pipeline holds only when that buffer is full. Register
// writes take effect at once and are meant for an empty pipeline.
module polar_scan_lookup_coordinates_top import psl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	psl_cfg_if.sink    cfg,
	psl_req_if.sink    req,
	psl_res_if.source  rsp
);

	// Registers
	logic [SIZE_W-1:0]   tw_q;
	logic [SIZE_W-1:0]   th_q;
	logic [ANGLE_W-1:0]  af_q;
	logic [ANGLE_W-1:0]  al_q;
	logic [RADIUS_W-1:0] rf_q;
	logic [RADIUS_W-1:0] rl_q;
	logic [CENTER_W-1:0] cx_q;
	logic [CENTER_W-1:0] cy_q;
	logic [DIV_W-1:0]    m_q;

	logic [SIZE_W-1:0]   w_eff;
	logic [SIZE_W-1:0]   h_eff;
	logic [SIZE_W-1:0]   w_m1;
	logic [SIZE_W-1:0]   h_m1;
	logic                adv;
	logic                room;

	// Front stages
	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PIX_W-1:0]         col_s1, row_s1;
	logic [PIX_W-1:0]         col_c, row_c;
	logic [27:0]              pa_s2;
	logic signed [27:0]       pb_s2;
	logic [RNUM_W-1:0]        ra_s2;
	logic signed [27:0]       rb_s2;
	logic signed [27:0]       adiff;
	logic signed [27:0]       rdiff;
	logic [SIZE_W-1:0]        hr;
	logic signed [PN_W-1:0]   pn_w;
	logic signed [27:0]       rs_w;
	logic signed [PN_W-1:0]   pn_s3;
	logic [RNUM_W-1:0]        rnum_s3;
	logic signed [PN_W-1:0]   pn_abs;
	logic [MOD_STEPS-1:0]     mag_s4;
	logic                     neg_s4;
	logic [RNUM_W-1:0]        rnum_s4;

	// Chains and side lines
	div_step_t                mod_c  [MOD_STEPS+1];
	div_step_t                frac_c [FRAC_STEPS+1];
	rot_step_t                rot_c  [CORDIC_LEN+1];
	div_step_t                ox_c   [OFS_STEPS+1];
	div_step_t                oy_c   [OFS_STEPS+1];
	logic                     mod_neg_q  [MOD_STEPS];
	logic [RNUM_W-1:0]        mod_rnum_q [MOD_STEPS];
	logic [RNUM_W-1:0]        frac_rnum_q [FRAC_STEPS];
	logic [RNUM_W-1:0]        rot_rnum_q [CORDIC_LEN];
	logic [1:0]               rot_quad_q [CORDIC_LEN];
	logic [1:0]               ofs_neg_q  [OFS_STEPS];

	// Back stages
	logic                     vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic [DIV_W-1:0]         mod_rem;
	logic [DIV_W-1:0]         rmod_s5;
	logic [RNUM_W-1:0]        rnum_s5;
	logic signed [CX_W-1:0]   fx, fy;
	logic signed [CX_W-1:0]   ax_w, ay_w;
	logic                     sx, sy;
	logic [1:0]               quad;
	logic [MAG_W-1:0]         cmag, smag;
	logic                     cneg, sneg;
	logic [MAG_W-1:0]         cmag_s6, smag_s6;
	logic                     cneg_s6, sneg_s6;
	logic [RNUM_W-1:0]        rnum_s6;
	logic [PROD_W-1:0]        px_s7, py_s7;
	logic                     cneg_s7, sneg_s7;
	logic [PROD_W:0]          half_d;
	logic [PROD_W:0]          sx_w, sy_w;
	logic [DIV_W-1:0]         nx_s8, ny_s8;
	logic                     cneg_s8, sneg_s8;
	logic [15:0]              qx, qy;
	logic signed [17:0]       ofx, ofy;
	logic signed [17:0]       sumx, sumy;
	coord_t                   res_s9;

	function automatic logic signed [COORD_W-1:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			return 16'sh8000;
		end
		return v[COORD_W-1:0];
	endfunction

	// Configuration port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= RST_TARGET_WIDTH;
			th_q <= RST_TARGET_HEIGHT;
			af_q <= RST_ANGLE_FIRST;
			al_q <= RST_ANGLE_LAST;
			rf_q <= RST_RADIUS_FIRST;
			rl_q <= RST_RADIUS_LAST;
			cx_q <= RST_CENTER_X;
			cy_q <= RST_CENTER_Y;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_TARGET_WIDTH:  tw_q <= cfg.data[SIZE_W-1:0];
				REG_TARGET_HEIGHT: th_q <= cfg.data[SIZE_W-1:0];
				REG_ANGLE_FIRST:   af_q <= cfg.data[ANGLE_W-1:0];
				REG_ANGLE_LAST:    al_q <= cfg.data[ANGLE_W-1:0];
				REG_RADIUS_FIRST:  rf_q <= cfg.data[RADIUS_W-1:0];
				REG_RADIUS_LAST:   rl_q <= cfg.data[RADIUS_W-1:0];
				REG_CENTER_X:      cx_q <= cfg.data[CENTER_W-1:0];
				REG_CENTER_Y:      cy_q <= cfg.data[CENTER_W-1:0];
				default:           tw_q <= tw_q;
			endcase
		end
	end

	// Zero sizes count as one
	assign w_eff = (tw_q == '0) ? SIZE_W'(1) : tw_q;
	assign h_eff = (th_q == '0) ? SIZE_W'(1) : th_q;
	assign w_m1  = w_eff - SIZE_W'(1);
	assign h_m1  = h_eff - SIZE_W'(1);

	// One full turn in the width's units
	always_ff @(posedge clk) begin
		m_q <= DIV_W'(w_eff) * DIV_W'(TURN_CENTI);
	end

	assign adv       = room;
	assign req.ready = adv;

	// Front: clamp, products, sums, magnitude
	assign col_c = ({1'b0, req.column} > w_m1) ? w_m1[PIX_W-1:0] : req.column;
	assign row_c = ({1'b0, req.row} > h_m1) ? h_m1[PIX_W-1:0] : req.row;
	assign adiff = $signed({1'b0, al_q}) - $signed({1'b0, af_q});
	assign rdiff = $signed({1'b0, rl_q}) - $signed({1'b0, rf_q});
	assign hr    = h_m1 - SIZE_W'(row_s1);
	assign pn_w  = $signed({2'b0, pa_s2}) + PN_W'(pb_s2);
	assign rs_w  = $signed({2'b0, ra_s2}) + rb_s2;
	assign pn_abs = pn_s3[PN_W-1] ? -pn_s3 : pn_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1  <= col_c;
			row_s1  <= row_c;
			pa_s2   <= 28'(af_q) * 28'(w_eff);
			pb_s2   <= $signed({17'b0, col_s1}) * adiff;
			ra_s2   <= RNUM_W'(rf_q) * RNUM_W'(h_eff);
			rb_s2   <= $signed({16'b0, hr}) * rdiff;
			pn_s3   <= pn_w;
			rnum_s3 <= rs_w[RNUM_W-1:0];
			mag_s4  <= pn_abs[MOD_STEPS-1:0];
			neg_s4  <= pn_s3[PN_W-1];
			rnum_s4 <= rnum_s3;
		end
	end

	// Angle modulo one turn
	assign mod_c[0] = '{vld: vld_s4, rem: '0,
	                    word: {mag_s4, {(WORD_W-MOD_STEPS){1'b0}}}};

	for (genvar g = 0; g < MOD_STEPS; g++) begin : g_mod
		psl_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.divisor (m_q),
			.d_i     (mod_c[g]),
			.d_o     (mod_c[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mod_neg_q[0]  <= neg_s4;
			mod_rnum_q[0] <= rnum_s4;
			for (int k = 1; k < MOD_STEPS; k++) begin
				mod_neg_q[k]  <= mod_neg_q[k-1];
				mod_rnum_q[k] <= mod_rnum_q[k-1];
			end
		end
	end

	// Negative angles wrap from the top of the turn
	assign mod_rem = mod_c[MOD_STEPS].rem;

	always_ff @(posedge clk) begin
		if (adv) begin
			rmod_s5 <= (mod_neg_q[MOD_STEPS-1] && mod_rem != '0) ? m_q - mod_rem
			                                                    : mod_rem;
			rnum_s5 <= mod_rnum_q[MOD_STEPS-1];
		end
	end

	// Binary angle: fraction of the turn, 32 bits
	assign frac_c[0] = '{vld: vld_s5, rem: rmod_s5, word: '0};

	for (genvar g = 0; g < FRAC_STEPS; g++) begin : g_frac
		psl_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.divisor (m_q),
			.d_i     (frac_c[g]),
			.d_o     (frac_c[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frac_rnum_q[0] <= rnum_s5;
			for (int k = 1; k < FRAC_STEPS; k++) begin
				frac_rnum_q[k] <= frac_rnum_q[k-1];
			end
		end
	end

	// Rotation over the residual angle inside the quadrant
	assign rot_c[0] = '{vld: frac_c[FRAC_STEPS].vld,
	                    x: CX_W'(CORDIC_GAIN_INV),
	                    y: '0,
	                    z: $signed({2'b0, frac_c[FRAC_STEPS].word[WORD_W-3:0]})};

	for (genvar g = 0; g < CORDIC_LEN; g++) begin : g_rot
		psl_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.step   (STEP_W'(g)),
			.r_i    (rot_c[g]),
			.r_o    (rot_c[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rot_rnum_q[0] <= frac_rnum_q[FRAC_STEPS-1];
			rot_quad_q[0] <= frac_c[FRAC_STEPS].word[WORD_W-1:WORD_W-2];
			for (int k = 1; k < CORDIC_LEN; k++) begin
				rot_rnum_q[k] <= rot_rnum_q[k-1];
				rot_quad_q[k] <= rot_quad_q[k-1];
			end
		end
	end

	// Quadrant map into sign and magnitude of cosine and sine
	assign fx   = rot_c[CORDIC_LEN].x;
	assign fy   = rot_c[CORDIC_LEN].y;
	assign sx   = fx[CX_W-1];
	assign sy   = fy[CX_W-1];
	assign ax_w = sx ? -fx : fx;
	assign ay_w = sy ? -fy : fy;
	assign quad = rot_quad_q[CORDIC_LEN-1];

	always_comb begin
		unique case (quad)
			2'd0: begin
				cmag = ax_w[MAG_W-1:0]; cneg = sx;
				smag = ay_w[MAG_W-1:0]; sneg = sy;
			end
			2'd1: begin
				cmag = ay_w[MAG_W-1:0]; cneg = !sy;
				smag = ax_w[MAG_W-1:0]; sneg = sx;
			end
			2'd2: begin
				cmag = ax_w[MAG_W-1:0]; cneg = !sx;
				smag = ay_w[MAG_W-1:0]; sneg = !sy;
			end
			default: begin
				cmag = ay_w[MAG_W-1:0]; cneg = sy;
				smag = ax_w[MAG_W-1:0]; sneg = !sx;
			end
		endcase
	end

	// Scale by the radius numerator, add half the divisor, drop the 2^30 part
	assign half_d = (PROD_W+1)'(h_eff) << 29;
	assign sx_w   = {1'b0, px_s7} + half_d;
	assign sy_w   = {1'b0, py_s7} + half_d;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmag_s6 <= cmag;
			smag_s6 <= smag;
			cneg_s6 <= cneg;
			sneg_s6 <= sneg;
			rnum_s6 <= rot_rnum_q[CORDIC_LEN-1];
			px_s7   <= PROD_W'(rnum_s6) * PROD_W'(cmag_s6);
			py_s7   <= PROD_W'(rnum_s6) * PROD_W'(smag_s6);
			cneg_s7 <= cneg_s6;
			sneg_s7 <= sneg_s6;
			nx_s8   <= sx_w[PROD_W:30];
			ny_s8   <= sy_w[PROD_W:30];
			cneg_s8 <= cneg_s7;
			sneg_s8 <= sneg_s7;
		end
	end

	// Divide by the height; the quotient fits 16 bits, so start with the top bits
	assign ox_c[0] = '{vld: vld_s8, rem: {16'b0, nx_s8[DIV_W-1:16]},
	                   word: {nx_s8[15:0], 16'b0}};
	assign oy_c[0] = '{vld: vld_s8, rem: {16'b0, ny_s8[DIV_W-1:16]},
	                   word: {ny_s8[15:0], 16'b0}};

	for (genvar g = 0; g < OFS_STEPS; g++) begin : g_ofs
		psl_div_cell u_cell_x (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.divisor (DIV_W'(h_eff)),
			.d_i     (ox_c[g]),
			.d_o     (ox_c[g+1])
		);
		psl_div_cell u_cell_y (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.divisor (DIV_W'(h_eff)),
			.d_i     (oy_c[g]),
			.d_o     (oy_c[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ofs_neg_q[0] <= {cneg_s8, sneg_s8};
			for (int k = 1; k < OFS_STEPS; k++) begin
				ofs_neg_q[k] <= ofs_neg_q[k-1];
			end
		end
	end

	// Apply sign, add the origin, saturate
	assign qx   = ox_c[OFS_STEPS].word[15:0];
	assign qy   = oy_c[OFS_STEPS].word[15:0];
	assign ofx  = ofs_neg_q[OFS_STEPS-1][1] ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
	assign ofy  = ofs_neg_q[OFS_STEPS-1][0] ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
	assign sumx = 18'($signed(cx_q)) + ofx;
	assign sumy = 18'($signed(cy_q)) + ofy;

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s9.source_x <= sat16(sumx);
			res_s9.source_y <= sat16(sumy);
		end
	end

	// Valid bits of the single stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= mod_c[MOD_STEPS].vld;
			vld_s6 <= rot_c[CORDIC_LEN].vld;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= ox_c[OFS_STEPS].vld;
		end
	end

	psl_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (adv && vld_s9),
		.data_i (res_s9),
		.room   (room),
		.rsp    (rsp)
	);

	// Checks
	a_mod_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		mod_c[MOD_STEPS].vld |-> (mod_c[MOD_STEPS].rem < m_q))
		else $error("angle remainder not below one turn");

	a_ofs_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		ox_c[OFS_STEPS].vld |-> (oy_c[OFS_STEPS].vld
		                         && ox_c[OFS_STEPS].rem < DIV_W'(h_eff)
		                         && oy_c[OFS_STEPS].rem < DIV_W'(h_eff)))
		else $error("offset division lanes out of step or remainder too large");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> vld_s1)
		else $error("accepted request did not enter the pipeline");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && vld_s9 |=> vld_s9 && $stable(res_s9))
		else $error("last stage changed while the pipeline was held");

	a_full_shows: assert property (@(posedge clk) disable iff (!arst_n)
		!room |-> rsp.valid)
		else $error("result buffer full but no result offered");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench of the polar scan lookup: table-driven and random pixel requests checked in order.
module tb_top;
	import psl_pkg::*;

	localparam int ROT_STEPS    = 16;
	localparam longint GAIN_START = 652032874;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 100;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 120;
	localparam int PRINT_LIMIT  = 40;

	typedef struct {
		int cfg_set;
		int column;
		int row;
		bit typed;
		int want_x;
		int want_y;
	} dir_row_t;

	logic clk;
	logic arst_n;

	psl_cfg_if cfg_ch();
	psl_req_if req_ch();
	psl_res_if res_ch();

	polar_scan_lookup_coordinates_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (res_ch)
	);

	// Register settings of the table, in register order; set zero is the reset state
	logic [CFG_DATA_W-1:0] cfg_sets [11][8] = '{
		'{16'd512,   16'd512,   16'd23300, 16'd30800, 16'd1856,  16'd8640,  16'd5440,  16'd8576},
		'{16'd16,    16'd16,    16'd0,     16'd0,     16'd16,    16'd16,    16'd0,     16'd0},
		'{16'd16,    16'd16,    16'd9000,  16'd9000,  16'd16,    16'd16,    16'd0,     16'd0},
		'{16'd16,    16'd16,    16'd18000, 16'd18000, 16'd16,    16'd16,    16'd0,     16'd0},
		'{16'd16,    16'd16,    16'd27000, 16'd27000, 16'd16,    16'd16,    16'd0,     16'd0},
		'{16'd0,     16'd0,     16'd0,     16'd36000, 16'd32,    16'd16000, 16'd100,   16'hFF9C},
		'{16'd16,    16'd16,    16'd45000, 16'd45000, 16'd64,    16'd64,    16'h4000,  16'h3FFF},
		'{16'd16,    16'd16,    16'd18000, 16'd18000, 16'hFFFF,  16'hFFFF,  16'hC000,  16'd0},
		'{16'd100,   16'd50,    16'd30000, 16'd6000,  16'd16000, 16'd0,     16'd0,     16'd0},
		'{16'h0FFF,  16'h0FFF,  16'd0,     16'd36000, 16'd0,     16'd16000, 16'd16000, 16'hC180},
		'{16'd2048,  16'd2048,  16'd35999, 16'd65535, 16'd16000, 16'd1,     16'h7FFF,  16'h8000}
	};

	dir_row_t dir_rows [24] = '{
		'{0, 0, 0, 1'b0, 0, 0},
		'{0, 511, 511, 1'b0, 0, 0},
		'{0, 2047, 2047, 1'b0, 0, 0},
		'{0, 256, 100, 1'b0, 0, 0},
		'{0, 0, 511, 1'b0, 0, 0},
		'{1, 0, 0, 1'b1, 16, 0},
		'{1, 15, 15, 1'b1, 16, 0},
		'{1, 2047, 2047, 1'b1, 16, 0},
		'{2, 5, 7, 1'b1, 0, 16},
		'{3, 0, 0, 1'b1, -16, 0},
		'{4, 2047, 0, 1'b1, 0, -16},
		'{5, 2047, 2047, 1'b1, 132, -100},
		'{5, 0, 0, 1'b1, 132, -100},
		'{6, 3, 9, 1'b1, -16384, 16447},
		'{7, 0, 2047, 1'b0, 0, 0},
		'{7, 9, 0, 1'b0, 0, 0},
		'{8, 0, 0, 1'b0, 0, 0},
		'{8, 99, 49, 1'b0, 0, 0},
		'{8, 50, 25, 1'b0, 0, 0},
		'{8, 2047, 0, 1'b0, 0, 0},
		'{9, 2047, 0, 1'b0, 0, 0},
		'{9, 0, 2047, 1'b0, 0, 0},
		'{9, 1024, 1024, 1'b0, 0, 0},
		'{10, 2047, 2047, 1'b0, 0, 0}
	};

	// Register copy used for prediction
	logic [SIZE_W-1:0]          tgt_width  = 12'd512;
	logic [SIZE_W-1:0]          tgt_height = 12'd512;
	logic [ANGLE_W-1:0]         ang_first  = 16'd23300;
	logic [ANGLE_W-1:0]         ang_last   = 16'd30800;
	logic [RADIUS_W-1:0]        rad_first  = 14'd1856;
	logic [RADIUS_W-1:0]        rad_last   = 14'd8640;
	logic signed [CENTER_W-1:0] org_x      = 15'sd5440;
	logic signed [CENTER_W-1:0] org_y      = 15'sd8576;

	coord_t pending_coords [$];
	int     mismatches   = 0;
	int     results_seen = 0;
	bit     hold_wanted  = 1'b0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic longint arctan(input int step);
		case (step)
			0:  return 536870912;
			1:  return 316933406;
			2:  return 167458907;
			3:  return 85004756;
			4:  return 42667331;
			5:  return 21354465;
			6:  return 10679838;
			7:  return 5340245;
			8:  return 2670163;
			9:  return 1335087;
			10: return 667544;
			11: return 333772;
			12: return 166886;
			13: return 83443;
			14: return 41722;
			15: return 20861;
			default: return 0;
		endcase
	endfunction

	// Round to nearest, ties away from zero; d is positive
	function automatic longint round_div(input longint n, input longint d);
		longint mag, q;
		mag = (n < 0) ? -n : n;
		q = (mag + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return COORD_W'(v);
	endfunction

	function automatic coord_t lookup_source(input logic [PIX_W-1:0] col_in,
			input logic [PIX_W-1:0] row_in);
		longint w, h, col, row, span, num, wrapped, rnum, den;
		longint x, y, z, dx, dy, c, s;
		longint unsigned frac;
		logic [31:0] ba;
		int i;
		coord_t res;
		w = (tgt_width == '0) ? 1 : longint'(tgt_width);
		h = (tgt_height == '0) ? 1 : longint'(tgt_height);
		col = longint'(col_in);
		row = longint'(row_in);
		if (col > w - 1)
			col = w - 1;
		if (row > h - 1)
			row = h - 1;

		// fold the interpolated angle into one turn, then scale to a binary angle
		span = w * TURN_CENTI;
		num = longint'(ang_first) * w + col * (longint'(ang_last) - longint'(ang_first));
		wrapped = num % span;
		if (wrapped < 0)
			wrapped += span;
		frac = ($unsigned(wrapped) << 32) / $unsigned(span);
		ba = frac[31:0];

		x = GAIN_START;
		y = 0;
		z = longint'(ba[29:0]);
		for (i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= arctan(i);
			end else begin
				x += dx;
				y -= dy;
				z += arctan(i);
			end
		end
		case (ba[31:30])
			2'd0: begin
				c = x;
				s = y;
			end
			2'd1: begin
				c = -y;
				s = x;
			end
			2'd2: begin
				c = -x;
				s = -y;
			end
			default: begin
				c = y;
				s = -x;
			end
		endcase

		rnum = longint'(rad_first) * h + (h - 1 - row) * (longint'(rad_last) - longint'(rad_first));
		den = h * (longint'(1) << 30);
		res.source_x = clamp_coord(longint'(org_x) + round_div(rnum * c, den));
		res.source_y = clamp_coord(longint'(org_y) + round_div(rnum * s, den));
		return res;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_reg(input int lo, input int hi);
		int pick, v;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			v = lo;
		else if (pick == 1)
			v = hi;
		else if (pick == 2)
			v = 0;
		else if (pick == 3)
			v = 'hFFFF;
		else if (pick == 4)
			v = $urandom_range(0, 'hFFFF);
		else
			v = lo + int'($urandom_range(0, hi - lo));
		return v[CFG_DATA_W-1:0];
	endfunction

	// Mostly inside the current size, now and then anywhere to hit the clamp
	function automatic logic [PIX_W-1:0] pick_index(input logic [SIZE_W-1:0] size);
		int lim;
		lim = (size == '0) ? 0 : int'(size) - 1;
		if (lim > 2047)
			lim = 2047;
		if ($urandom_range(0, 4) == 0)
			return PIX_W'($urandom_range(0, 2047));
		return PIX_W'($urandom_range(0, lim));
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch at result %0d: %s", results_seen, what);
	endtask

	task automatic apply_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_TARGET_WIDTH:  tgt_width  = d[SIZE_W-1:0];
			REG_TARGET_HEIGHT: tgt_height = d[SIZE_W-1:0];
			REG_ANGLE_FIRST:   ang_first  = d[ANGLE_W-1:0];
			REG_ANGLE_LAST:    ang_last   = d[ANGLE_W-1:0];
			REG_RADIUS_FIRST:  rad_first  = d[RADIUS_W-1:0];
			REG_RADIUS_LAST:   rad_last   = d[RADIUS_W-1:0];
			REG_CENTER_X:      org_x      = d[CENTER_W-1:0];
			REG_CENTER_Y:      org_y      = d[CENTER_W-1:0];
			default: ;
		endcase
	endtask

	// Keep valid high across the whole burst of writes, drop it after the last
	task automatic write_regs(input logic [CFG_DATA_W-1:0] vals [8]);
		int i;
		for (i = 0; i < 8; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= cfg_reg_t'(i);
			cfg_ch.data  <= vals[i];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			apply_reg(cfg_reg_t'(i), vals[i]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_coords.size() != 0)
			@(posedge clk);
	endtask

	task automatic pace(input bit burst);
		int gap;
		if (!burst && $urandom_range(0, 2) == 0) begin
			gap = idle_len();
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
			input bit typed, input coord_t want);
		req_ch.valid  <= 1'b1;
		req_ch.column <= col;
		req_ch.row    <= row;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_coords.push_back(typed ? want : lookup_source(col, row));
	endtask

	// Result side: check each accepted result, then decide ready for the next edge
	initial begin : result_side
		int stall_left, mode_left, hold_left;
		bit eager, hold_started;
		coord_t want;
		stall_left = 0;
		mode_left = 0;
		hold_left = 0;
		eager = 1'b0;
		hold_started = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (pending_coords.size() == 0) begin
					report_mismatch($sformatf("unexpected result (%0d, %0d)",
						res_ch.source_x, res_ch.source_y));
				end else begin
					want = pending_coords.pop_front();
					if (res_ch.source_x !== want.source_x)
						report_mismatch($sformatf("source_x %0d, expected %0d",
							res_ch.source_x, want.source_x));
					if (res_ch.source_y !== want.source_y)
						report_mismatch($sformatf("source_y %0d, expected %0d",
							res_ch.source_y, want.source_y));
				end
			end
			if (hold_wanted && !hold_started) begin
				hold_started = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(20, 80);
					eager = ($urandom_range(0, 2) == 0);
				end
				mode_left--;
				if (stall_left > 0) begin
					stall_left--;
					res_ch.ready <= 1'b0;
				end else if (!eager && $urandom_range(0, 3) == 0) begin
					stall_left = idle_len() - 1;
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= 1'b1;
				end
			end
		end
	end

	initial begin : request_side
		int cur_set, n, p, k;
		bit burst;
		logic [CFG_DATA_W-1:0] vals [8];
		coord_t want;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.column = '0;
		req_ch.row = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TARGET_WIDTH;
		cfg_ch.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Table first: reset state, corners of the fan, clamping and register extremes
		cur_set = 0;
		for (n = 0; n < 24; n++) begin
			if (dir_rows[n].cfg_set != cur_set) begin
				drain_results();
				cur_set = dir_rows[n].cfg_set;
				write_regs(cfg_sets[cur_set]);
			end
			pace(1'b0);
			want.source_x = COORD_W'(dir_rows[n].want_x);
			want.source_y = COORD_W'(dir_rows[n].want_y);
			send_pixel(PIX_W'(dir_rows[n].column), PIX_W'(dir_rows[n].row),
				dir_rows[n].typed, want);
		end

		want = '0;
		for (p = 0; p < RAND_PHASES; p++) begin
			drain_results();
			vals[REG_TARGET_WIDTH]  = rand_reg(16, 2048);
			vals[REG_TARGET_HEIGHT] = rand_reg(16, 2048);
			vals[REG_ANGLE_FIRST]   = rand_reg(0, 36000);
			vals[REG_ANGLE_LAST]    = rand_reg(0, 36000);
			vals[REG_RADIUS_FIRST]  = rand_reg(0, 16000);
			vals[REG_RADIUS_LAST]   = rand_reg(0, 16000);
			vals[REG_CENTER_X]      = rand_reg(-16000, 16000);
			vals[REG_CENTER_Y]      = rand_reg(-16000, 16000);
			write_regs(vals);
			// Third phase: sink holds off while requests keep coming back to back
			burst = (p == 2) || ($urandom_range(0, 3) == 0);
			if (p == 2)
				hold_wanted = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				pace(burst);
				send_pixel(pick_index(tgt_width), pick_index(tgt_height), 1'b0, want);
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
